// File: rtl/core/stx_etx_frame_checker_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the STX/ETX frame checker
// Concurrent assertion wrappers. They are empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef STX_ETX_FRAME_CHECKER_CORE_MACROS_SVH
`define STX_ETX_FRAME_CHECKER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge out of reset.
`define SEFC_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define SEFC_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SEFC_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg)
`define SEFC_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg)

`endif

`endif

// File: rtl/core/sefc_pkg.sv
// ----------------------------------------------------------------------------
// sefc_pkg
// Character codes, result status codes and helpers for the frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package sefc_pkg;

  localparam logic [7:0] CH_STX   = 8'h02;
  localparam logic [7:0] CH_ETX   = 8'h03;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7E;

  // Bytes of checksum and line end that follow the ETX.
  localparam int unsigned TRAILER_LEN = 3;

  localparam int unsigned CNT_W  = 9;
  localparam int unsigned LEN_W  = 10;
  localparam int unsigned DATA_W = 40;

  typedef enum logic [1:0] {
    ST_DROP  = 2'd0,
    ST_BYTE  = 2'd1,
    ST_DONE  = 2'd2,
    ST_ERROR = 2'd3
  } status_t;

  // Bit 4 flags a valid hex digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/stx_etx_frame_checker_core.sv
// ----------------------------------------------------------------------------
// stx_etx_frame_checker_core
// Checks STX, printable body, ETX, two hex XOR checksum digits, CR or LF.
// ----------------------------------------------------------------------------
// Each received byte gives exactly one result beat, registered in the cycle
// after it is taken. The per-byte check is a few compares and an XOR feeding
// the result register directly, so a byte can be taken in every cycle and the
// sustained rate is one byte per clock while out_tready stays high. in_tready is
// low only while a result beat sits in the result register and out_tready is
// low. Bytes outside a frame, STX apart, give a dropped status with all other
// fields zero; any fault ends the frame with an error status and a new STX hunt.
`default_nettype none

`include "stx_etx_frame_checker_core_macros.svh"

module stx_etx_frame_checker_core #(
  parameter int unsigned MAX_FRAME  = 256,
  parameter int unsigned MAX_FIELDS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte

  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] byte_position, [8] delimiter_seen, [12:9] delimiter_index,
  // [17:13] field_count, [26:18] frame_length, [34:27] computed_xor, [39:35] zero
  output logic [sefc_pkg::DATA_W-1:0] out_tdata,
  output logic [1:0]       out_tuser   // [1:0] frame_status
);

  localparam int unsigned DW = $clog2(MAX_FIELDS + 1);
  localparam logic [sefc_pkg::LEN_W-1:0] MAX_LEN = sefc_pkg::LEN_W'(MAX_FRAME);
  localparam logic [DW-1:0] MAX_DELIM = DW'(MAX_FIELDS);

  // Frame state.
  logic                       in_frame_r, in_frame_nxt;
  logic [sefc_pkg::CNT_W-1:0] byte_cnt_r, byte_cnt_nxt;
  logic [sefc_pkg::CNT_W-1:0] etx_place_r, etx_place_nxt;
  logic [7:0]                 xor_r, xor_nxt;
  logic [7:0]                 hex_r, hex_nxt;
  logic                       hex_bad_r, hex_bad_nxt;
  logic [DW-1:0]              delim_r, delim_nxt;

  // Result register.
  logic                       out_valid_r;
  sefc_pkg::status_t          status_r, status_nxt;
  logic [7:0]                 pos_r, pos_nxt;
  logic                       seen_r, seen_nxt;
  logic [3:0]                 didx_r, didx_nxt;
  logic [4:0]                 fcnt_r, fcnt_nxt;
  logic [8:0]                 flen_r, flen_nxt;
  logic [7:0]                 cxor_r, cxor_nxt;

  logic                       in_fire;
  logic [7:0]                 ch;
  logic [sefc_pkg::LEN_W-1:0] len, etx_ext, etx_end;
  logic                       ok, done;
  logic [4:0]                 hd;
  logic [5:0]                 delim_old6, delim_new6;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = !out_valid_r || out_tready;
  assign ch        = in_tdata;
  assign len       = {1'b0, byte_cnt_r} + sefc_pkg::LEN_W'(1);
  assign etx_ext   = {1'b0, etx_place_r};
  assign etx_end   = etx_ext + sefc_pkg::LEN_W'(sefc_pkg::TRAILER_LEN);
  assign hd        = sefc_pkg::hex_digit(ch);

  always_comb begin
    in_frame_nxt  = in_frame_r;
    byte_cnt_nxt  = byte_cnt_r;
    etx_place_nxt = etx_place_r;
    xor_nxt       = xor_r;
    hex_nxt       = hex_r;
    hex_bad_nxt   = hex_bad_r;
    delim_nxt     = delim_r;
    ok            = 1'b1;
    done          = 1'b0;
    delim_old6    = 6'(delim_r);
    delim_new6    = 6'(delim_r);
    status_nxt    = sefc_pkg::ST_DROP;
    pos_nxt       = 8'd0;
    seen_nxt      = 1'b0;
    didx_nxt      = 4'd0;
    fcnt_nxt      = 5'd0;
    flen_nxt      = 9'd0;
    cxor_nxt      = 8'd0;

    if (!in_frame_r) begin
      if (ch == sefc_pkg::CH_STX) begin
        in_frame_nxt  = 1'b1;
        byte_cnt_nxt  = sefc_pkg::CNT_W'(1);
        etx_place_nxt = sefc_pkg::CNT_W'(MAX_FRAME);
        xor_nxt       = 8'd0;
        hex_nxt       = 8'd0;
        hex_bad_nxt   = 1'b0;
        delim_nxt     = '0;
        status_nxt    = sefc_pkg::ST_BYTE;
      end
    end else if (len > MAX_LEN) begin
      // Overflow: the byte is not counted and the position saturates.
      in_frame_nxt = 1'b0;
      status_nxt   = sefc_pkg::ST_ERROR;
      pos_nxt      = 8'hFF;
      fcnt_nxt     = delim_old6[4:0];
      cxor_nxt     = xor_r;
    end else begin
      if (ch == sefc_pkg::CH_ETX) begin
        ok            = len < etx_ext;
        etx_place_nxt = len[sefc_pkg::CNT_W-1:0];
      end else if (ch == sefc_pkg::CH_CR || ch == sefc_pkg::CH_LF) begin
        ok   = (etx_end == len) && !hex_bad_r && (hex_r == xor_r);
        done = 1'b1;
      end else if (len >= etx_end) begin
        ok = 1'b0;
      end else begin
        ok = (ch >= sefc_pkg::CH_PRINT_LO) && (ch <= sefc_pkg::CH_PRINT_HI);
        // The two bytes right after ETX are the checksum digits.
        if (etx_ext < MAX_LEN && len > etx_ext &&
            len <= etx_ext + sefc_pkg::LEN_W'(2)) begin
          if (!hd[4]) begin
            hex_bad_nxt = 1'b1;
          end else begin
            hex_nxt = {hex_r[3:0], hd[3:0]};
          end
        end
      end

      if (ch != sefc_pkg::CH_ETX && len < etx_ext) begin
        xor_nxt = xor_r ^ ch;
      end

      if ((ch == sefc_pkg::CH_COMMA || ch == sefc_pkg::CH_ETX) && delim_r < MAX_DELIM) begin
        seen_nxt   = 1'b1;
        didx_nxt   = delim_old6[3:0];
        delim_nxt  = delim_r + DW'(1);
        delim_new6 = 6'(delim_nxt);
      end

      byte_cnt_nxt = len[sefc_pkg::CNT_W-1:0];

      priority if (!ok) begin
        status_nxt   = sefc_pkg::ST_ERROR;
        in_frame_nxt = 1'b0;
      end else if (done) begin
        status_nxt   = sefc_pkg::ST_DONE;
        flen_nxt     = len[8:0];
        in_frame_nxt = 1'b0;
      end else begin
        status_nxt = sefc_pkg::ST_BYTE;
      end

      pos_nxt  = byte_cnt_r[7:0];
      fcnt_nxt = delim_new6[4:0];
      cxor_nxt = xor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r  <= 1'b0;
      byte_cnt_r  <= '0;
      etx_place_r <= sefc_pkg::CNT_W'(MAX_FRAME);
      xor_r       <= 8'd0;
      hex_r       <= 8'd0;
      hex_bad_r   <= 1'b0;
      delim_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        in_frame_r  <= in_frame_nxt;
        byte_cnt_r  <= byte_cnt_nxt;
        etx_place_r <= etx_place_nxt;
        xor_r       <= xor_nxt;
        hex_r       <= hex_nxt;
        hex_bad_r   <= hex_bad_nxt;
        delim_r     <= delim_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r <= status_nxt;
      pos_r    <= pos_nxt;
      seen_r   <= seen_nxt;
      didx_r   <= didx_nxt;
      fcnt_r   <= fcnt_nxt;
      flen_r   <= flen_nxt;
      cxor_r   <= cxor_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {5'd0, cxor_r, flen_r, fcnt_r, didx_r, seen_r, pos_r};

  `SEFC_ASSERT_NXT(a_result_follows, clk, rst_n, in_fire, out_valid_r, "accepted byte gave no result")
  `SEFC_ASSERT_IMP(a_done_has_length, clk, rst_n, out_valid_r && status_r == sefc_pkg::ST_DONE, flen_r != 9'd0, "valid frame with zero length")
  `SEFC_ASSERT_IMP(a_length_only_done, clk, rst_n, out_valid_r && status_r != sefc_pkg::ST_DONE, flen_r == 9'd0, "frame length outside valid completion")
  `SEFC_ASSERT_IMP(a_no_delim_hunting, clk, rst_n, out_valid_r && status_r == sefc_pkg::ST_DROP, !seen_r && fcnt_r == 5'd0, "delimiter reported while hunting")

endmodule

`default_nettype wire

// File: tb/sv/stx_etx_frame_result_checker.sv
// ----------------------------------------------------------------------------
// stx_etx_frame_result_checker
// Watches both streams of the frame checker, predicts every result beat from
// the accepted bytes and compares it field by field with what comes out.
// ----------------------------------------------------------------------------
`default_nettype none

module stx_etx_frame_result_checker #(
  parameter int unsigned MAX_FRAME  = 256,
  parameter int unsigned MAX_FIELDS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [7:0]  in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [sefc_pkg::DATA_W-1:0] out_tdata,
  input  wire logic [1:0]  out_tuser,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    sefc_pkg::status_t status;
    logic [7:0] pos;
    logic       seen;
    logic [3:0] didx;
    logic [4:0] fields;
    logic [8:0] flen;
    logic [7:0] xr;
  } frame_result_t;

  // Tracked frame state.
  bit          in_frm;
  int unsigned byte_cnt;
  int unsigned etx_at;
  logic [7:0]  xsum;
  logic [7:0]  hexv;
  bit          hex_err;
  int unsigned delims;

  frame_result_t pending_results[$];
  frame_result_t want;
  int mismatches = 0;
  int backlog = 0;

  assign fail_count = mismatches;
  assign pending    = backlog;

  task automatic report(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int exp_val);
    if (got != exp_val) begin
      report($sformatf("%s is %0d, wanted %0d", name, got, exp_val));
    end
  endtask

  function automatic frame_result_t predict_byte(input logic [7:0] ch);
    frame_result_t r;
    int unsigned   len;
    bit            ok;
    bit            done;
    int            digit;
    r = '0;
    ok = 1'b1;
    done = 1'b0;
    if (!in_frm) begin
      if (ch == sefc_pkg::CH_STX) begin
        in_frm   = 1'b1;
        byte_cnt = 1;
        etx_at   = MAX_FRAME;
        xsum     = '0;
        hexv     = '0;
        hex_err  = 1'b0;
        delims   = 0;
        r.status = sefc_pkg::ST_BYTE;
      end else begin
        r.status = sefc_pkg::ST_DROP;
      end
      return r;
    end

    len = byte_cnt + 1;
    // A byte past the longest frame is an error and is not counted.
    if (len > MAX_FRAME) begin
      in_frm   = 1'b0;
      r.status = sefc_pkg::ST_ERROR;
      r.pos    = 8'hFF;
      r.fields = 5'(delims);
      r.xr     = xsum;
      return r;
    end

    if (ch == sefc_pkg::CH_ETX) begin
      ok = (len < etx_at);
      etx_at = len;
    end else if (ch == sefc_pkg::CH_CR || ch == sefc_pkg::CH_LF) begin
      ok = (etx_at + sefc_pkg::TRAILER_LEN == len) && !hex_err && (hexv == xsum);
      done = 1'b1;
    end else if (len >= etx_at + sefc_pkg::TRAILER_LEN) begin
      ok = 1'b0;
    end else begin
      ok = (ch >= sefc_pkg::CH_PRINT_LO && ch <= sefc_pkg::CH_PRINT_HI);
      if (etx_at < MAX_FRAME && len > etx_at && len <= etx_at + 2) begin
        if (ch >= 8'h30 && ch <= 8'h39) digit = ch - 8'h30;
        else if (ch >= 8'h41 && ch <= 8'h46) digit = ch - 8'h41 + 10;
        else if (ch >= 8'h61 && ch <= 8'h66) digit = ch - 8'h61 + 10;
        else digit = -1;
        if (digit < 0) hex_err = 1'b1;
        else hexv = {hexv[3:0], 4'(digit)};
      end
    end

    if (len > 1 && len < etx_at) xsum = xsum ^ ch;

    if ((ch == sefc_pkg::CH_COMMA || ch == sefc_pkg::CH_ETX) && delims < MAX_FIELDS) begin
      r.seen = 1'b1;
      r.didx = 4'(delims);
      delims++;
    end

    byte_cnt = len;

    if (!ok) begin
      r.status = sefc_pkg::ST_ERROR;
      in_frm = 1'b0;
    end else if (done) begin
      r.status = sefc_pkg::ST_DONE;
      r.flen = 9'(len);
      in_frm = 1'b0;
    end else begin
      r.status = sefc_pkg::ST_BYTE;
    end
    r.pos    = 8'(len - 1);
    r.fields = 5'(delims);
    r.xr     = xsum;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_frm   = 1'b0;
      byte_cnt = 0;
      etx_at   = MAX_FRAME;
      xsum     = '0;
      hexv     = '0;
      hex_err  = 1'b0;
      delims   = 0;
      pending_results.delete();
      backlog <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        pending_results.push_back(predict_byte(in_tdata));
      end
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          report("result beat with no byte outstanding");
        end else begin
          want = pending_results.pop_front();
          check_field("frame_status", out_tuser, want.status);
          check_field("byte_position", out_tdata[7:0], want.pos);
          check_field("delimiter_seen", out_tdata[8], want.seen);
          check_field("delimiter_index", out_tdata[12:9], want.didx);
          check_field("field_count", out_tdata[17:13], want.fields);
          check_field("frame_length", out_tdata[26:18], want.flen);
          check_field("computed_xor", out_tdata[34:27], want.xr);
        end
      end
      backlog <= pending_results.size();
    end
  end

endmodule

`default_nettype wire

// File: tb/sv/stx_etx_frame_checker_core_tb.sv
// ----------------------------------------------------------------------------
// stx_etx_frame_checker_core_tb
// Feeds the frame checker well-formed and broken STX/ETX frames mixed with
// line noise, under random source gaps and sink stalls, and gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module stx_etx_frame_checker_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_FRAME  = 256;
  localparam int unsigned MAX_FIELDS = 16;

  typedef enum {
    FR_GOOD, FR_BAD_SUM, FR_BAD_DIGIT, FR_SHORT_SUM, FR_EXTRA, FR_TWO_ETX,
    FR_NONPRINT, FR_EARLY_EOL, FR_OVERFLOW, FR_ETX_LAST, FR_NOISE
  } frame_kind_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [sefc_pkg::DATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;
  int fail_count;
  int pending;

  logic [7:0] frame_q[$];
  int  items_sent = 0;
  int  burst_left = 0;
  bit  no_gaps = 1'b0;
  int  stall_mode = 0;
  int  stall_left = 0;
  int  stall_tick = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  stx_etx_frame_checker_core #(
    .MAX_FRAME  (MAX_FRAME),
    .MAX_FIELDS (MAX_FIELDS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  stx_etx_frame_result_checker #(
    .MAX_FRAME  (MAX_FRAME),
    .MAX_FIELDS (MAX_FIELDS)
  ) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // The sink switches between always ready, mostly ready, mostly stalled and
  // a fixed duty pattern, each held for a random stretch.
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= ((stall_tick % 7) < 3);
    endcase
  end

  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (!no_gaps && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    items_sent++;
  endtask

  task automatic send_queued;
    while (frame_q.size() != 0) send_byte(frame_q.pop_front());
  endtask

  // Holds the source off until the checker has seen every result come back.
  task automatic drain_results;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
    if (nib < 4'd10) return 8'h30 + 8'(nib);
    return (upper ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
  endfunction

  task automatic build_frame(input frame_kind_t kind, input int body_len,
                             input int comma_pct);
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] spoil;
    int twist;
    if (kind == FR_NOISE) begin
      repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom));
      return;
    end
    twist = $urandom_range(0, 1);
    sum = 8'h00;
    frame_q.push_back(sefc_pkg::CH_STX);
    repeat (body_len) begin
      b = ($urandom_range(0, 99) < comma_pct) ? sefc_pkg::CH_COMMA
                                              : 8'($urandom_range(32, 126));
      sum ^= b;
      frame_q.push_back(b);
    end
    if (kind == FR_NONPRINT || kind == FR_EARLY_EOL) begin
      if (kind == FR_EARLY_EOL) begin
        spoil = twist ? sefc_pkg::CH_CR : sefc_pkg::CH_LF;
      end else begin
        do spoil = 8'($urandom);
        while ((spoil >= sefc_pkg::CH_PRINT_LO && spoil <= sefc_pkg::CH_PRINT_HI) ||
               spoil == sefc_pkg::CH_ETX || spoil == sefc_pkg::CH_CR ||
               spoil == sefc_pkg::CH_LF);
      end
      frame_q.insert($urandom_range(1, frame_q.size()), spoil);
    end
    if (kind == FR_OVERFLOW) return;
    frame_q.push_back(sefc_pkg::CH_ETX);
    if (kind == FR_ETX_LAST) return;
    if (kind == FR_BAD_SUM) sum ^= 8'($urandom_range(1, 255));
    if (kind == FR_TWO_ETX && twist == 0) frame_q.push_back(sefc_pkg::CH_ETX);
    if (kind == FR_BAD_DIGIT && twist == 0) begin
      frame_q.push_back(8'($urandom_range(8'h67, 8'h7A)));
    end else begin
      frame_q.push_back(hex_char(sum[7:4], $urandom_range(0, 1)));
    end
    if (kind == FR_TWO_ETX && twist == 1) frame_q.push_back(sefc_pkg::CH_ETX);
    if (kind != FR_SHORT_SUM) begin
      if (kind == FR_BAD_DIGIT && twist == 1) begin
        frame_q.push_back($urandom_range(0, 1) ? sefc_pkg::CH_COMMA
                                               : 8'($urandom_range(8'h47, 8'h5A)));
      end else begin
        frame_q.push_back(hex_char(sum[3:0], $urandom_range(0, 1)));
      end
    end
    if (kind == FR_EXTRA) begin
      do b = 8'($urandom);
      while (b == sefc_pkg::CH_CR || b == sefc_pkg::CH_LF);
      frame_q.push_back(b);
    end
    frame_q.push_back($urandom_range(0, 1) ? sefc_pkg::CH_CR : sefc_pkg::CH_LF);
  endtask

  initial begin
    frame_kind_t kind;
    int pick;
    int body_len;
    int comma_pct;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: noise extremes, a short frame with comma and tilde closed by
    // CR, an empty frame closed by LF, an early line end and a second ETX.
    frame_q = '{8'hFF, 8'h00,
                sefc_pkg::CH_STX, sefc_pkg::CH_COMMA, 8'h7E, sefc_pkg::CH_PRINT_LO,
                sefc_pkg::CH_ETX, 8'h37, 8'h32, sefc_pkg::CH_CR,
                sefc_pkg::CH_STX, sefc_pkg::CH_ETX, 8'h30, 8'h30, sefc_pkg::CH_LF,
                sefc_pkg::CH_STX, 8'h41, sefc_pkg::CH_CR,
                sefc_pkg::CH_STX, sefc_pkg::CH_ETX, sefc_pkg::CH_ETX};
    send_queued();
    drain_results();

    // Longest valid frame, an overflowing one and ETX in the last slot.
    build_frame(FR_GOOD, MAX_FRAME - 5, 5);
    build_frame(FR_OVERFLOW, MAX_FRAME, 10);
    build_frame(FR_ETX_LAST, MAX_FRAME - 2, 0);
    send_queued();
    drain_results();

    while (items_sent < 1000) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 50) kind = FR_GOOD;
      else if (pick < 56) kind = FR_BAD_SUM;
      else if (pick < 62) kind = FR_BAD_DIGIT;
      else if (pick < 67) kind = FR_SHORT_SUM;
      else if (pick < 72) kind = FR_EXTRA;
      else if (pick < 77) kind = FR_TWO_ETX;
      else if (pick < 82) kind = FR_NONPRINT;
      else if (pick < 87) kind = FR_EARLY_EOL;
      else kind = FR_NOISE;
      body_len = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 12) : $urandom_range(13, 40);
      case ($urandom_range(0, 2))
        0: comma_pct = 0;
        1: comma_pct = 10;
        default: comma_pct = 60;
      endcase
      if ($urandom_range(0, 4) == 0) build_frame(FR_NOISE, 0, 0);
      build_frame(kind, body_len, comma_pct);
      send_queued();
      if ($urandom_range(0, 19) == 0) drain_results();
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
